// File: hdl/latency_histogram_fail_counters_defines.svh
// Assertion macros shared by the histogram block.
`ifndef LATENCY_HISTOGRAM_FAIL_COUNTERS_DEFINES_SVH
`define LATENCY_HISTOGRAM_FAIL_COUNTERS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under reset.
`define LHFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhfc assertion failed");
// Next-cycle implication under reset.
`define LHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhfc assertion failed");
`else
`define LHFC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/lhfc_pkg.sv
package lhfc_pkg;

    localparam int NUM_BUCKETS = 11;
    localparam int NUM_REASONS = 9;
    localparam int NUM_SLOTS   = NUM_BUCKETS + NUM_REASONS + 3;

    localparam int LAT_W  = 31;
    localparam int CNT_W  = 64;
    localparam int SLOT_W = 5;
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int RSN_W  = $clog2(NUM_REASONS);

    localparam logic [SLOT_W-1:0] COUNT_SLOT  = SLOT_W'(NUM_BUCKETS);
    localparam logic [SLOT_W-1:0] SUM_SLOT    = SLOT_W'(NUM_BUCKETS + 1);
    localparam logic [SLOT_W-1:0] REASON_BASE = SLOT_W'(NUM_BUCKETS + 2);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // One classified item travelling from the front end to the counter engine.
    typedef struct packed {
        logic             snap;
        logic [BKT_W-1:0] bucket;
        logic [LAT_W-1:0] lat;
        logic             fail;
        logic [RSN_W-1:0] reason;
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } t_back_state;

    // Upper bucket bounds in whole microseconds; bounds past the table are open.
    function automatic logic [31:0] bound_us(input int unsigned idx);
        logic [31:0] b;
        unique case (idx)
            0:       b = 32'd5000;
            1:       b = 32'd10000;
            2:       b = 32'd25000;
            3:       b = 32'd50000;
            4:       b = 32'd100000;
            5:       b = 32'd250000;
            6:       b = 32'd500000;
            7:       b = 32'd1000000;
            8:       b = 32'd2500000;
            9:       b = 32'd5000000;
            10:      b = 32'd10000000;
            default: b = 32'hFFFF_FFFF;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/latency_histogram_fail_counters.sv
// Latency histogram with failure-reason counters.
//
// Input channel (i_valid/o_ready): each transfer is a record (i_action = 0)
// or a snapshot request (i_action = 1). A record drops the clamped latency
// into one of eleven buckets (5 ms .. 5 s, overflow into the last), bumps
// the sample count and the microsecond sum, and on a failure bumps the
// reason counter and the failure total. A record produces no output.
// Output channel (o_valid/i_ready): a snapshot streams 23 transfers, slot 0
// to 22 (buckets, count, sum, reasons, failure total), o_last on slot 22.
//
// A front end classifies each item combinationally into a 4-entry queue; a
// counter engine behind it applies one record per cycle or streams one
// snapshot slot per cycle through a single output register while the
// receiver takes them. Records sustain one per cycle while no snapshot
// streams; a snapshot holds the engine while it pops it and streams its 23
// slots, and the queue keeps taking items. A snapshot's first result passes
// the queue, the pop into the stream state and the output register; a record counts when it is popped.
// When the receiver stalls, the output register holds and the slot walk
// halts; the queue fills and o_ready drops once four items wait.
// Reset clears every counter, the queue and the output valid flag.
module latency_histogram_fail_counters (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic signed [31:0]           i_latency_us,
    input  logic                         i_ok,
    input  logic [3:0]                   i_reason_code,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lhfc_pkg::SLOT_W-1:0]  o_slot,
    output logic [lhfc_pkg::CNT_W-1:0]   o_value,
    output logic                         o_last
);

    lhfc_pkg::t_op in_op, head_op;
    logic          q_full, q_empty, q_pop;

    // Classify the incoming item.
    lhfc_front u_front (
        .i_action      (i_action),
        .i_latency_us  (i_latency_us),
        .i_ok          (i_ok),
        .i_reason_code (i_reason_code),
        .o_op          (in_op)
    );

    // Decouple the front end from the counter engine.
    lhfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (in_op),
        .i_pop   (q_pop),
        .o_head  (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign o_ready = ~q_full;

    // Apply records, stream snapshots.
    lhfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_op),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_slot  (o_slot),
        .o_value (o_value),
        .o_last  (o_last)
    );

endmodule

// File: hdl/lhfc_front.sv
module lhfc_front (
    input  logic                i_action,
    input  logic signed [31:0]  i_latency_us,
    input  logic                i_ok,
    input  logic [3:0]          i_reason_code,
    output lhfc_pkg::t_op       o_op
);

    logic [lhfc_pkg::LAT_W-1:0] lat;
    logic [lhfc_pkg::BKT_W-1:0] bucket;
    logic [lhfc_pkg::RSN_W-1:0] reason;

    // Clamp negatives to zero.
    assign lat = i_latency_us[31] ? '0 : i_latency_us[30:0];

    // Compare bank; the lowest bound that is not exceeded wins.
    always_comb begin
        bucket = lhfc_pkg::BKT_W'(lhfc_pkg::NUM_BUCKETS - 1);
        for (int i = lhfc_pkg::NUM_BUCKETS - 2; i >= 0; i--) begin
            if ({1'b0, lat} <= lhfc_pkg::bound_us(i)) begin
                bucket = lhfc_pkg::BKT_W'(i);
            end
        end
    end

    // Fold unknown codes into the last reason counter.
    assign reason = (i_reason_code >= 4'(lhfc_pkg::NUM_REASONS - 1))
                  ? lhfc_pkg::RSN_W'(lhfc_pkg::NUM_REASONS - 1)
                  : i_reason_code[lhfc_pkg::RSN_W-1:0];

    always_comb begin
        o_op.snap   = i_action;
        o_op.bucket = bucket;
        o_op.lat    = lat;
        o_op.fail   = ~i_ok;
        o_op.reason = reason;
    end

endmodule

// File: hdl/lhfc_fifo.sv
module lhfc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lhfc_pkg::t_op i_data,
    input  logic          i_pop,
    output lhfc_pkg::t_op o_head,
    output logic          o_full,
    output logic          o_empty
);

    lhfc_pkg::t_op                r_mem [lhfc_pkg::FIFO_DEPTH];
    logic [lhfc_pkg::FPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [lhfc_pkg::FCNT_W-1:0]  r_count;
    logic                         push, pop;

    assign o_full  = (r_count == lhfc_pkg::FCNT_W'(lhfc_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_push & ~o_full;
    assign pop     = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop) r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: hdl/lhfc_back.sv
`include "latency_histogram_fail_counters_defines.svh"

module lhfc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lhfc_pkg::t_op                i_head,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lhfc_pkg::SLOT_W-1:0]  o_slot,
    output logic [lhfc_pkg::CNT_W-1:0]   o_value,
    output logic                         o_last
);

    lhfc_pkg::t_back_state        r_state, n_state;
    logic [lhfc_pkg::SLOT_W-1:0]  r_idx;
    logic [lhfc_pkg::CNT_W-1:0]   r_bucket [lhfc_pkg::NUM_BUCKETS];
    logic [lhfc_pkg::CNT_W-1:0]   r_reason [lhfc_pkg::NUM_REASONS];
    logic [lhfc_pkg::CNT_W-1:0]   r_count, r_sum, r_fail_total;
    logic                         r_out_valid, n_out_valid;
    logic [lhfc_pkg::SLOT_W-1:0]  r_slot;
    logic [lhfc_pkg::CNT_W-1:0]   r_value, sel_value;
    logic                         r_last;
    logic                         adv, load, rec;
    logic [lhfc_pkg::SLOT_W-1:0]  rsn_off;

    assign adv = ~r_out_valid | i_ready;
    assign rec = (r_state == lhfc_pkg::BK_IDLE) & ~i_empty & ~i_head.snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lhfc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_ready;
        o_pop       = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            lhfc_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.snap) n_state = lhfc_pkg::BK_STREAM;
                end
            end
            lhfc_pkg::BK_STREAM: begin
                if (adv) begin
                    load        = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_idx == lhfc_pkg::LAST_SLOT) n_state = lhfc_pkg::BK_IDLE;
                end
            end
            default: n_state = lhfc_pkg::BK_IDLE;
        endcase
    end

    // Slot walk: restart on each snapshot, advance per loaded result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (r_state == lhfc_pkg::BK_IDLE) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Counter bank, all wrapping at 64 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lhfc_pkg::NUM_BUCKETS; i++) r_bucket[i] <= '0;
            for (int i = 0; i < lhfc_pkg::NUM_REASONS; i++) r_reason[i] <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_fail_total <= '0;
        end else if (rec) begin
            r_bucket[i_head.bucket] <= r_bucket[i_head.bucket] + 1'b1;
            r_count <= r_count + 1'b1;
            r_sum   <= r_sum + lhfc_pkg::CNT_W'(i_head.lat);
            if (i_head.fail) begin
                r_reason[i_head.reason] <= r_reason[i_head.reason] + 1'b1;
                r_fail_total            <= r_fail_total + 1'b1;
            end
        end
    end

    assign rsn_off = r_idx - lhfc_pkg::REASON_BASE;

    always_comb begin
        if (r_idx < lhfc_pkg::COUNT_SLOT) begin
            sel_value = r_bucket[r_idx[lhfc_pkg::BKT_W-1:0]];
        end else if (r_idx == lhfc_pkg::COUNT_SLOT) begin
            sel_value = r_count;
        end else if (r_idx == lhfc_pkg::SUM_SLOT) begin
            sel_value = r_sum;
        end else if (r_idx < lhfc_pkg::LAST_SLOT) begin
            sel_value = r_reason[rsn_off[lhfc_pkg::RSN_W-1:0]];
        end else begin
            sel_value = r_fail_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot  <= r_idx;
            r_value <= sel_value;
            r_last  <= (r_idx == lhfc_pkg::LAST_SLOT);
        end
    end

    assign o_valid = r_out_valid;
    assign o_slot  = r_slot;
    assign o_value = r_value;
    assign o_last  = r_last;

    `LHFC_ASSERT_NOW(a_last_slot, i_clk, i_rst_n, r_out_valid && r_last, r_slot == lhfc_pkg::LAST_SLOT)
    `LHFC_ASSERT_NOW(a_no_rec_in_stream, i_clk, i_rst_n, r_state == lhfc_pkg::BK_STREAM, !rec && !o_pop)
    `LHFC_ASSERT_NEXT(a_stream_ends, i_clk, i_rst_n, load && r_idx == lhfc_pkg::LAST_SLOT, r_state == lhfc_pkg::BK_IDLE && r_out_valid && r_last)
    `LHFC_ASSERT_NEXT(a_stream_starts, i_clk, i_rst_n, o_pop && i_head.snap, r_state == lhfc_pkg::BK_STREAM && r_idx == '0)

endmodule
